>>> rtl/pisp_pkg.sv
package pisp_pkg;

  localparam int ACC_BITS_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int VALUE_W = 64;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W = 7;

  localparam logic CFG_ALLOW_NEGATIVE = 1'b0;
  localparam logic CFG_WIDTH_LIMIT = 1'b1;

  localparam logic [LIMIT_W-1:0] WIDTH_LIMIT_RESET = 7'd64;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NEG     = 3'd1,
    ST_QUOTE   = 3'd2,
    ST_INVALID = 3'd3,
    ST_WIDE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_START  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_XSEEN  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_TRAIL  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    RX_BIN = 2'd0,
    RX_OCT = 2'd1,
    RX_DEC = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  typedef struct packed {
    logic       is_space;
    logic       is_plus;
    logic       is_minus;
    logic       is_quote;
    logic       is_x;
    logic       is_b;
    logic       is_hex;
    logic [3:0] digit;
    logic       last;
  } char_info_t;

endpackage

>>> rtl/prefixed_integer_string_parser.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata: char_code; tlast: is_last
// m_axis    out        tdata: value [63:0], status [66:64]
// cfg       in         cfg_index: register number; cfg_data: register value
//
// One character is taken per cycle while the queue is not full; the accumulator updates with one shift-add per beat.
// A result is registered at the end of the parser stage and again in the finish stage before it leaves.
// Reset clears the parse state and sets allow_negative to 1 and width_limit to 64.
// A four-beat queue between classifier and parser absorbs output stalls.
module prefixed_integer_string_parser #(
  parameter int ACC_BITS = pisp_pkg::ACC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // char_code
  input  logic                         s_axis_tlast,  // is_last
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [71:0]                  m_axis_tdata,  // value, status, zero fill
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [pisp_pkg::LIMIT_W-1:0] cfg_data
);
  import pisp_pkg::*;

  logic allow_negative;
  logic [LIMIT_W-1:0] width_limit;
  logic q_full;
  logic q_push;
  char_info_t push_item;
  logic q_pop;
  logic q_valid;
  char_info_t pop_item;
  logic end_valid;
  logic end_ready;
  logic [ACC_BITS-1:0] end_acc;
  logic end_minus;
  status_t end_status;
  logic [LIMIT_W-1:0] end_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_negative <= 1'b1;
      width_limit <= WIDTH_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALLOW_NEGATIVE: allow_negative <= cfg_data[0];
        CFG_WIDTH_LIMIT: width_limit <= cfg_data;
        default: width_limit <= width_limit;
      endcase
    end
  end

  pisp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  pisp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  pisp_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .allow_negative (allow_negative),
    .width_limit    (width_limit),
    .q_valid        (q_valid),
    .q_item         (pop_item),
    .q_pop          (q_pop),
    .end_valid      (end_valid),
    .end_ready      (end_ready),
    .end_acc        (end_acc),
    .end_minus      (end_minus),
    .end_status     (end_status),
    .end_limit      (end_limit)
  );

  pisp_finish #(
    .ACC_BITS (ACC_BITS)
  ) u_finish (
    .clk           (clk),
    .rst           (rst),
    .end_valid     (end_valid),
    .end_ready     (end_ready),
    .end_acc       (end_acc),
    .end_minus     (end_minus),
    .end_status    (end_status),
    .end_limit     (end_limit),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> rtl/pisp_front.sv
module pisp_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // char_code
  input  logic                s_axis_tlast,  // is_last
  input  logic                q_full,
  output logic                q_push,
  output pisp_pkg::char_info_t q_item
);
  import pisp_pkg::*;

  logic [7:0] upper;

  assign s_axis_tready = !q_full;
  assign q_push = s_axis_tvalid && !q_full;
  assign upper = s_axis_tdata & CASE_MASK;

  always_comb begin
    q_item = '0;
    q_item.last = s_axis_tlast;
    q_item.is_space = (s_axis_tdata == CH_SPACE) ||
                      ((s_axis_tdata >= CH_TAB) && (s_axis_tdata <= CH_CR));
    q_item.is_plus = (s_axis_tdata == CH_PLUS);
    q_item.is_minus = (s_axis_tdata == CH_MINUS);
    q_item.is_quote = (s_axis_tdata == CH_QUOTE);
    q_item.is_x = (s_axis_tdata == CH_LOWER_X) || (s_axis_tdata == CH_UPPER_X);
    q_item.is_b = (s_axis_tdata == CH_LOWER_B) || (s_axis_tdata == CH_UPPER_B);
    if ((s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE)) begin
      q_item.is_hex = 1'b1;
      q_item.digit = 4'(s_axis_tdata - CH_ZERO);
    end else if ((upper >= CH_UPPER_A) && (upper <= CH_UPPER_F)) begin
      q_item.is_hex = 1'b1;
      q_item.digit = 4'(upper - CH_UPPER_A + 8'd10);
    end
  end

endmodule

>>> rtl/pisp_queue.sv
module pisp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pisp_pkg::char_info_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output pisp_pkg::char_info_t pop_item
);
  import pisp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  char_info_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/pisp_back.sv
module pisp_back #(
  parameter int ACC_BITS = pisp_pkg::ACC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         allow_negative,
  input  logic [pisp_pkg::LIMIT_W-1:0] width_limit,
  input  logic                         q_valid,
  input  pisp_pkg::char_info_t         q_item,
  output logic                         q_pop,
  output logic                         end_valid,
  input  logic                         end_ready,
  output logic [ACC_BITS-1:0]          end_acc,
  output logic                         end_minus,
  output pisp_pkg::status_t            end_status,
  output logic [pisp_pkg::LIMIT_W-1:0] end_limit
);
  import pisp_pkg::*;

  localparam int EXT_W = ACC_BITS + 4;

  phase_t phase, phase_next;
  radix_t radix_mode, radix_mode_next;
  logic minus_seen, minus_seen_next;
  logic quote_pending, quote_pending_next;
  logic [ACC_BITS-1:0] accumulator, accumulator_next;
  status_t sticky_error, sticky_error_next;

  logic active;
  logic start_path;
  logic do_digit;
  radix_t digit_radix;
  logic in_radix;
  logic [EXT_W-1:0] acc_ext;
  logic [EXT_W-1:0] product;
  logic [EXT_W-1:0] sum;

  assign q_pop = q_valid && (!q_item.last || !end_valid || end_ready);
  assign active = (sticky_error == ST_OK) || (sticky_error == ST_WIDE);
  assign acc_ext = EXT_W'(accumulator);

  always_comb begin
    product = acc_ext << 4;
    case (digit_radix)
      RX_BIN: product = acc_ext << 1;
      RX_OCT: product = acc_ext << 3;
      RX_DEC: product = (acc_ext << 3) + (acc_ext << 1);
      default: product = acc_ext << 4;
    endcase
    sum = product + EXT_W'(q_item.digit);
  end

  always_comb begin
    in_radix = q_item.is_hex;
    case (digit_radix)
      RX_BIN: in_radix = q_item.is_hex && (q_item.digit < 4'd2);
      RX_OCT: in_radix = q_item.is_hex && (q_item.digit < 4'd8);
      RX_DEC: in_radix = q_item.is_hex && (q_item.digit < 4'd10);
      default: in_radix = q_item.is_hex;
    endcase
  end

  always_comb begin
    phase_next = phase;
    radix_mode_next = radix_mode;
    minus_seen_next = minus_seen;
    quote_pending_next = quote_pending;
    accumulator_next = accumulator;
    sticky_error_next = sticky_error;
    start_path = 1'b0;
    do_digit = 1'b0;
    digit_radix = radix_mode;

    if (active) begin
      unique case (phase)
        PH_LEAD: begin
          if (q_item.is_space) begin
            phase_next = phase;
          end else if (q_item.is_plus) begin
            phase_next = PH_START;
          end else if (q_item.is_minus) begin
            if (allow_negative) begin
              minus_seen_next = 1'b1;
              phase_next = PH_START;
            end else begin
              sticky_error_next = ST_NEG;
            end
          end else begin
            start_path = 1'b1;
          end
        end
        PH_START: start_path = 1'b1;
        PH_ZERO: begin
          phase_next = PH_DIGITS;
          if (q_item.is_x) begin
            radix_mode_next = RX_HEX;
          end else if (q_item.is_b) begin
            radix_mode_next = RX_BIN;
          end else begin
            radix_mode_next = RX_OCT;
            digit_radix = RX_OCT;
            do_digit = 1'b1;
          end
        end
        PH_XSEEN: begin
          if (q_item.is_quote) begin
            radix_mode_next = RX_HEX;
            quote_pending_next = 1'b1;
            phase_next = PH_DIGITS;
          end else begin
            sticky_error_next = ST_INVALID;
          end
        end
        PH_DIGITS: do_digit = 1'b1;
        PH_TRAIL: begin
          if (!q_item.is_space) begin
            sticky_error_next = ST_INVALID;
          end
        end
        default: phase_next = PH_LEAD;
      endcase

      if (start_path) begin
        if (q_item.is_hex && (q_item.digit == 4'd0)) begin
          phase_next = PH_ZERO;
        end else if (q_item.is_x) begin
          phase_next = PH_XSEEN;
        end else begin
          radix_mode_next = RX_DEC;
          phase_next = PH_DIGITS;
          digit_radix = RX_DEC;
          do_digit = 1'b1;
        end
      end

      if (do_digit) begin
        if (in_radix) begin
          accumulator_next = sum[ACC_BITS-1:0];
          if ((sum[EXT_W-1:ACC_BITS] != '0) && (sticky_error == ST_OK)) begin
            sticky_error_next = ST_WIDE;
          end
        end else if (quote_pending) begin
          if (q_item.is_quote) begin
            quote_pending_next = 1'b0;
            phase_next = PH_TRAIL;
          end else begin
            sticky_error_next = ST_QUOTE;
          end
        end else if (q_item.is_space) begin
          phase_next = PH_TRAIL;
        end else begin
          sticky_error_next = ST_INVALID;
        end
      end
    end

    if (q_item.last) begin
      if (quote_pending_next && (sticky_error_next == ST_OK || sticky_error_next == ST_WIDE)) begin
        sticky_error_next = ST_QUOTE;
      end
      if ((phase_next == PH_XSEEN) &&
          (sticky_error_next == ST_OK || sticky_error_next == ST_WIDE)) begin
        sticky_error_next = ST_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      radix_mode <= RX_DEC;
      minus_seen <= 1'b0;
      quote_pending <= 1'b0;
      accumulator <= '0;
      sticky_error <= ST_OK;
      end_valid <= 1'b0;
    end else begin
      end_valid <= (q_pop && q_item.last) || (end_valid && !end_ready);
      if (q_pop) begin
        if (q_item.last) begin
          phase <= PH_LEAD;
          radix_mode <= RX_DEC;
          minus_seen <= 1'b0;
          quote_pending <= 1'b0;
          accumulator <= '0;
          sticky_error <= ST_OK;
        end else begin
          phase <= phase_next;
          radix_mode <= radix_mode_next;
          minus_seen <= minus_seen_next;
          quote_pending <= quote_pending_next;
          accumulator <= accumulator_next;
          sticky_error <= sticky_error_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      end_acc <= accumulator_next;
      end_minus <= minus_seen_next;
      end_status <= sticky_error_next;
      end_limit <= width_limit;
    end
  end

endmodule

>>> rtl/pisp_finish.sv
module pisp_finish #(
  parameter int ACC_BITS = pisp_pkg::ACC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         end_valid,
  output logic                         end_ready,
  input  logic [ACC_BITS-1:0]          end_acc,
  input  logic                         end_minus,
  input  pisp_pkg::status_t            end_status,
  input  logic [pisp_pkg::LIMIT_W-1:0] end_limit,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [71:0]                  m_axis_tdata  // value, status, zero fill
);
  import pisp_pkg::*;

  localparam int EXT_W = (ACC_BITS > VALUE_W) ? ACC_BITS : VALUE_W;

  logic [ACC_BITS-1:0] acc_less_one;
  logic [EXT_W-1:0] acc_ext;
  logic [VALUE_W-1:0] magnitude;
  logic too_wide;
  status_t status_final;
  logic [VALUE_W-1:0] value_final;
  logic [VALUE_W-1:0] value_reg;
  status_t status_reg;

  assign end_ready = !m_axis_tvalid || m_axis_tready;
  assign acc_less_one = end_acc - ACC_BITS'(1);
  assign acc_ext = EXT_W'(end_acc);
  assign magnitude = acc_ext[VALUE_W-1:0];

  always_comb begin
    if (end_minus) begin
      too_wide = (end_acc != '0) &&
                 ((end_limit == '0) || ((acc_less_one >> (end_limit - 7'd1)) != '0));
    end else begin
      too_wide = (end_acc >> end_limit) != '0;
    end
    status_final = end_status;
    if ((end_status == ST_OK) && too_wide) begin
      status_final = ST_WIDE;
    end
    if (status_final != ST_OK) begin
      value_final = '0;
    end else if (end_minus) begin
      value_final = VALUE_W'(0) - magnitude;
    end else begin
      value_final = magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (end_ready) begin
      m_axis_tvalid <= end_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (end_ready && end_valid) begin
      value_reg <= value_final;
      status_reg <= status_final;
    end
  end

  assign m_axis_tdata = {5'd0, status_reg, value_reg};

endmodule

>>> tb/sv/literal_parse_checker.sv
`timescale 1ns / 100ps

module literal_parse_checker
  import pisp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                s_axis_tlast,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [71:0]         m_axis_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [LIMIT_W-1:0]  cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } parse_result_t;

  parse_result_t expected_q[$];
  parse_result_t want;

  logic               allow_neg;
  logic [LIMIT_W-1:0] width_lim;

  phase_t             phase_q;
  radix_t             radix_q;
  logic               minus_q;
  logic               quote_q;
  logic [VALUE_W-1:0] acc_q;
  status_t            err_q;

  function automatic void clear_parse();
    phase_q = PH_LEAD;
    radix_q = RX_DEC;
    minus_q = 1'b0;
    quote_q = 1'b0;
    acc_q = '0;
    err_q = ST_OK;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_x(logic [7:0] c);
    return c == CH_LOWER_X || c == CH_UPPER_X;
  endfunction

  // Errors other than overflow are final; overflow may still be replaced.
  function automatic void note_error(status_t code);
    if (err_q == ST_OK || err_q == ST_WIDE) err_q = code;
  endfunction

  function automatic int digit_value(logic [7:0] c);
    case (radix_q)
      RX_BIN: return (c >= CH_ZERO && c <= CH_ONE) ? int'(c - CH_ZERO) : -1;
      RX_OCT: return (c >= CH_ZERO && c <= CH_SEVEN) ? int'(c - CH_ZERO) : -1;
      RX_DEC: return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : -1;
      default: begin
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if ((c >= CH_LOWER_A && c <= CH_LOWER_F) || (c >= CH_UPPER_A && c <= CH_UPPER_F))
          return int'((c & CASE_MASK) - CH_UPPER_A) + 10;
        return -1;
      end
    endcase
  endfunction

  function automatic int unsigned radix_base(radix_t r);
    case (r)
      RX_BIN: return 2;
      RX_OCT: return 8;
      RX_DEC: return 10;
      default: return 16;
    endcase
  endfunction

  function automatic void shift_in(int unsigned base, int unsigned d);
    logic [VALUE_W+3:0] prod;
    prod = {4'd0, acc_q} * (VALUE_W + 4)'(base) + (VALUE_W + 4)'(d);
    acc_q = prod[VALUE_W-1:0];
    if (prod[VALUE_W+3:VALUE_W] != 4'd0 && err_q == ST_OK) err_q = ST_WIDE;
  endfunction

  function automatic void digit_step(logic [7:0] c);
    int d;
    d = digit_value(c);
    if (d >= 0) begin
      shift_in(radix_base(radix_q), d);
    end else if (quote_q) begin
      if (c == CH_QUOTE) begin
        quote_q = 1'b0;
        phase_q = PH_TRAIL;
      end else begin
        note_error(ST_QUOTE);
      end
    end else if (is_blank(c)) begin
      phase_q = PH_TRAIL;
    end else begin
      note_error(ST_INVALID);
    end
  endfunction

  function automatic void first_digit_step(logic [7:0] c);
    if (c == CH_ZERO) begin
      phase_q = PH_ZERO;
    end else if (is_x(c)) begin
      phase_q = PH_XSEEN;
    end else begin
      radix_q = RX_DEC;
      phase_q = PH_DIGITS;
      digit_step(c);
    end
  endfunction

  function automatic void char_step(logic [7:0] c);
    case (phase_q)
      PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == CH_PLUS) begin
            phase_q = PH_START;
          end else if (c == CH_MINUS) begin
            if (allow_neg) begin
              minus_q = 1'b1;
              phase_q = PH_START;
            end else begin
              note_error(ST_NEG);
            end
          end else begin
            first_digit_step(c);
          end
        end
      end
      PH_START: first_digit_step(c);
      PH_ZERO: begin
        phase_q = PH_DIGITS;
        if (is_x(c)) begin
          radix_q = RX_HEX;
        end else if (c == CH_LOWER_B || c == CH_UPPER_B) begin
          radix_q = RX_BIN;
        end else begin
          radix_q = RX_OCT;
          digit_step(c);
        end
      end
      PH_XSEEN: begin
        if (c == CH_QUOTE) begin
          radix_q = RX_HEX;
          quote_q = 1'b1;
          phase_q = PH_DIGITS;
        end else begin
          note_error(ST_INVALID);
        end
      end
      PH_DIGITS: digit_step(c);
      default: begin
        if (!is_blank(c)) note_error(ST_INVALID);
      end
    endcase
  endfunction

  function automatic int unsigned bit_len(logic [VALUE_W-1:0] v);
    for (int i = VALUE_W - 1; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic void finish_literal();
    int unsigned need;
    parse_result_t res;
    if (quote_q) note_error(ST_QUOTE);
    if (phase_q == PH_XSEEN) note_error(ST_INVALID);
    if (!minus_q) need = bit_len(acc_q);
    else if (acc_q == '0) need = 0;
    else need = bit_len(acc_q - 1'b1) + 1;
    if (err_q == ST_OK && need > width_lim) err_q = ST_WIDE;
    res.status = err_q;
    if (err_q != ST_OK) res.value = '0;
    else res.value = minus_q ? '0 - acc_q : acc_q;
    expected_q.push_back(res);
    clear_parse();
  endfunction

  function automatic void absorb_char(logic [7:0] c, logic is_last);
    if (err_q == ST_OK || err_q == ST_WIDE) char_step(c);
    if (is_last) finish_literal();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      allow_neg = 1'b1;
      width_lim = WIDTH_LIMIT_RESET;
      clear_parse();
      expected_q.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALLOW_NEGATIVE: allow_neg = cfg_data[0];
          CFG_WIDTH_LIMIT: width_lim = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) absorb_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no value expected: value %h, status %0d",
                 m_axis_tdata[63:0], m_axis_tdata[66:64]);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[63:0] !== want.value) begin
            $error("value: expected %h, actual %h", want.value, m_axis_tdata[63:0]);
            mismatches++;
          end
          if (m_axis_tdata[66:64] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[66:64]);
            mismatches++;
          end
        end
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pisp_pkg::*;

  localparam int CHAR_BUDGET = 1250;
  localparam int QUIET_LIMIT = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int LITERALS_PER_SETTING = 20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [71:0]        m_axis_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_ALLOW_NEGATIVE;
  logic [LIMIT_W-1:0] cfg_data = '0;

  int         mismatches;
  int         outstanding;
  bit         idle_en = 1'b1;
  int         sent_chars = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  int         literal_count;
  logic [7:0] literal_q[$];

  prefixed_integer_string_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  literal_parse_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(logic [7:0] c, logic is_last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    sent_chars++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(logic index, logic [LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apply_settings(logic allow_neg, logic [LIMIT_W-1:0] limit);
    wait_drained();
    write_reg(CFG_ALLOW_NEGATIVE, LIMIT_W'(allow_neg));
    write_reg(CFG_WIDTH_LIMIT, limit);
  endtask

  function automatic logic [7:0] random_blank();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] random_digit(radix_t r);
    int unsigned v;
    case (r)
      RX_BIN: return CH_ZERO + 8'($urandom_range(0, 1));
      RX_OCT: return CH_ZERO + 8'($urandom_range(0, 7));
      RX_DEC: return CH_ZERO + 8'($urandom_range(0, 9));
      default: begin
        v = $urandom_range(0, 21);
        if (v < 10) return CH_ZERO + 8'(v);
        if (v < 16) return CH_LOWER_A + 8'(v - 10);
        return CH_UPPER_A + 8'(v - 16);
      end
    endcase
  endfunction

  // Mostly well-formed literals with random content; the rest is corrupted or pure noise.
  task automatic make_literal();
    int kind;
    int style;
    int ndig;
    radix_t r;
    literal_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) literal_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) literal_q.push_back(random_blank());
    case ($urandom_range(0, 3))
      0: ;
      1: literal_q.push_back(CH_PLUS);
      default: literal_q.push_back(CH_MINUS);
    endcase
    style = $urandom_range(0, 4);
    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 5);
    case (style)
      1: begin
        r = RX_HEX;
        literal_q.push_back(CH_ZERO);
        literal_q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
      end
      2: begin
        r = RX_HEX;
        literal_q.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
        literal_q.push_back(CH_QUOTE);
      end
      3: begin
        r = RX_BIN;
        ndig = ndig * 3;
        literal_q.push_back(CH_ZERO);
        literal_q.push_back($urandom_range(0, 1) ? CH_LOWER_B : CH_UPPER_B);
      end
      4: begin
        r = RX_OCT;
        literal_q.push_back(CH_ZERO);
      end
      default: r = RX_DEC;
    endcase
    repeat (ndig) literal_q.push_back(random_digit(r));
    if (style == 2) literal_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 2)) literal_q.push_back(random_blank());
    if (literal_q.size() == 0) literal_q.push_back(random_digit(RX_DEC));
    if (kind <= 2) literal_q[$urandom_range(0, literal_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("0");
    send_text(" \t+42 ");
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    send_text("-9223372036854775808");
    send_text("-0x8000000000000001");
    send_text("0B1011");
    send_text("0777");
    send_text("08");
    send_text("0x");
    send_text("-");
    send_text("x'1F'");
    send_text("X'aB");
    send_text("x'12 '");
    send_text("x1");
    send_text("X");
    send_text("12a");
    send_text("99999999999999999999z");

    apply_settings(1'b0, LIMIT_W'(1));
    send_text("-5x'");
    send_text("+1");
    send_text("2");
    apply_settings(1'b1, LIMIT_W'(1));
    send_text("-1");
    send_text("-2");
    send_text("-0");

    literal_count = 0;
    while (sent_chars < CHAR_BUDGET) begin
      if (literal_count % LITERALS_PER_SETTING == 0) begin
        case ($urandom_range(0, 3))
          0: apply_settings(1'($urandom_range(0, 1)), LIMIT_W'(1));
          1: apply_settings(1'($urandom_range(0, 1)), WIDTH_LIMIT_RESET);
          default: apply_settings(1'($urandom_range(0, 1)), LIMIT_W'($urandom_range(1, 64)));
        endcase
        idle_en = $urandom_range(0, 3) != 0;
      end
      if (sent_chars > CHAR_BUDGET * 85 / 100) idle_en = 1'b0;
      make_literal();
      foreach (literal_q[i]) send_char(literal_q[i], i == literal_q.size() - 1);
      literal_count++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
